>>> hdl/piecewise_activation_unit_assert.svh
// Assertion macros for the piecewise activation unit checker.
`ifndef PIECEWISE_ACTIVATION_UNIT_ASSERT_SVH
`define PIECEWISE_ACTIVATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PWAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwau assertion failed");

// Next-cycle implication, disabled during reset.
`define PWAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwau assertion failed");

`endif

>>> hdl/pwau_pkg.sv
// Shared types, register indexes and mode codes for the piecewise activation unit.
package pwau_pkg;

    localparam int FRAC_BITS_DEFAULT = 12;
    localparam int DATA_W            = 16;
    localparam int MODE_W            = 4;
    localparam int CFG_INDEX_W       = 2;

    typedef logic signed [DATA_W-1:0] fx_t;
    typedef logic        [MODE_W-1:0] mode_t;
    typedef logic        [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic signed [2*DATA_W:0] wide_t;

    localparam cfg_index_t CFG_MODE   = 2'd0;
    localparam cfg_index_t CFG_SLOPE  = 2'd1;
    localparam cfg_index_t CFG_THRESH = 2'd2;

    localparam mode_t MODE_RELU         = 4'd0;
    localparam mode_t MODE_RELU_SLOPE   = 4'd1;
    localparam mode_t MODE_LEAKY        = 4'd2;
    localparam mode_t MODE_LEAKY_SLOPE  = 4'd3;
    localparam mode_t MODE_HSIG         = 4'd4;
    localparam mode_t MODE_HSIG_SLOPE   = 4'd5;
    localparam mode_t MODE_HTANH        = 4'd6;
    localparam mode_t MODE_HTANH_SLOPE  = 4'd7;
    localparam mode_t MODE_THRESH       = 4'd8;
    localparam mode_t MODE_THRESH_SLOPE = 4'd9;

    localparam mode_t RESET_MODE   = MODE_RELU;
    localparam fx_t   RESET_SLOPE  = 16'sd41;
    localparam fx_t   RESET_THRESH = 16'sd4096;

    localparam wide_t SAT_MAX = 33'sd32767;
    localparam wide_t SAT_MIN = -33'sd32768;

    function automatic fx_t sat16(input wide_t v);
        fx_t r;
        if (v > SAT_MAX)
        begin
            r = 16'sh7fff;
        end
        else if (v < SAT_MIN)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic wide_t widen(input fx_t v);
        return {{(DATA_W+1){v[DATA_W-1]}}, v};
    endfunction

endpackage

>>> hdl/piecewise_activation_unit.sv
// Piecewise-linear activation unit: one Q-format sample in, one activated value out.
//
// Takes one sample per clock whenever start is high; busy stays low, so every
// request is accepted. Each result appears on activated with done high for one
// cycle, in request order, once the request has passed the input register and
// the result register; the receiver cannot stall the unit and must take every
// result in that cycle. A single shared multiplier (leaky product or hard-sigmoid
// product) sits between the input register and the result register. Configuration
// writes are always accepted (cfg_ready is high) and must only be issued while no
// request is in flight; indexes beyond the threshold register are ignored.
module piecewise_activation_unit
    import pwau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  fx_t        sample,
    output logic       done,
    output fx_t        activated,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  fx_t        cfg_data
);

    localparam int ONE   = 1 << FRAC_BITS;
    localparam int HALF  = ONE / 2;
    localparam int FIFTH = (2 * ONE + 5) / 10;
    localparam int EDGE  = (5 * ONE) / 2;

    localparam logic signed [17:0] ONE_X  = 18'(ONE);
    localparam logic signed [17:0] EDGE_X = 18'(EDGE);
    localparam fx_t   FIFTH_FX = 16'(FIFTH);
    localparam wide_t ONE_W    = 33'(ONE);
    localparam wide_t HALF_W   = 33'(HALF);
    localparam wide_t FIFTH_W  = 33'(FIFTH);

    mode_t mode_reg;
    fx_t   negative_slope_reg;
    fx_t   threshold_reg;

    logic  in_valid_reg;
    fx_t   sample_reg;
    logic  out_valid_reg;
    fx_t   activated_reg;
    fx_t   activated_next;

    fx_t                     mult_b;
    logic signed [31:0]      product;
    logic signed [31:0]      shifted;
    wide_t                   shifted_w;
    wide_t                   x_w;
    logic signed [17:0]      x_x;
    wide_t                   y;
    logic                    x_pos;
    logic                    x_above_thresh;
    logic                    hsig_low;
    logic                    hsig_high;
    logic                    htanh_low;
    logic                    htanh_high;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = out_valid_reg;
    assign activated = activated_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= RESET_MODE;
            negative_slope_reg <= RESET_SLOPE;
            threshold_reg      <= RESET_THRESH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg           <= cfg_data[MODE_W-1:0];
                CFG_SLOPE:  negative_slope_reg <= cfg_data;
                CFG_THRESH: threshold_reg      <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= start && !busy;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            sample_reg <= sample;
        end
        if (in_valid_reg)
        begin
            activated_reg <= activated_next;
        end
    end

    always_comb
    begin
        x_w            = widen(sample_reg);
        x_x            = {{2{sample_reg[DATA_W-1]}}, sample_reg};
        mult_b         = (mode_reg == MODE_HSIG) ? FIFTH_FX : negative_slope_reg;
        product        = 32'(sample_reg) * 32'(mult_b);
        shifted        = product >>> FRAC_BITS;
        shifted_w      = {shifted[31], shifted};
        x_pos          = sample_reg > 16'sd0;
        x_above_thresh = sample_reg > threshold_reg;
        hsig_low       = x_x <= -EDGE_X;
        hsig_high      = x_x >= EDGE_X;
        htanh_low      = x_x <= -ONE_X;
        htanh_high     = x_x >= ONE_X;

        case (mode_reg)
            MODE_RELU:         y = x_pos ? x_w : '0;
            MODE_RELU_SLOPE:   y = x_pos ? ONE_W : '0;
            MODE_LEAKY:        y = x_pos ? x_w : shifted_w;
            MODE_LEAKY_SLOPE:  y = x_pos ? ONE_W : widen(negative_slope_reg);
            MODE_HSIG:
            begin
                if (hsig_low)
                begin
                    y = '0;
                end
                else if (hsig_high)
                begin
                    y = ONE_W;
                end
                else
                begin
                    y = shifted_w + HALF_W;
                end
            end
            MODE_HSIG_SLOPE:   y = (hsig_low || hsig_high) ? '0 : FIFTH_W;
            MODE_HTANH:
            begin
                if (htanh_low)
                begin
                    y = -ONE_W;
                end
                else if (htanh_high)
                begin
                    y = ONE_W;
                end
                else
                begin
                    y = x_w;
                end
            end
            MODE_HTANH_SLOPE:  y = (htanh_low || htanh_high) ? '0 : ONE_W;
            MODE_THRESH:       y = x_above_thresh ? x_w : '0;
            MODE_THRESH_SLOPE: y = x_above_thresh ? ONE_W : '0;
            default:           y = '0;
        endcase

        activated_next = sat16(y);
    end

endmodule

>>> hdl/pwau_checker.sv
// Port-level checker for the piecewise activation unit, bound into the unit itself.
`include "piecewise_activation_unit_assert.svh"

module pwau_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    `PWAU_ASSERT_NEXT(a_request_gives_result, clk, rst_n, start && !busy, ##1 done)
    `PWAU_ASSERT_IMPL(a_result_has_request, clk, rst_n, done, $past(start && !busy, 2))
    `PWAU_ASSERT_IMPL(a_cfg_never_stalls, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind piecewise_activation_unit pwau_checker u_pwau_checker (.*);

>>> tb/tb_top.sv
// Testbench for the piecewise activation unit: directed table, then random samples vs. a predictor.
`timescale 1ns / 100ps

module tb_top;
    import pwau_pkg::*;

    localparam longint FX_ONE   = longint'(1) << FRAC_BITS_DEFAULT;
    localparam longint FX_HALF  = FX_ONE / 2;
    localparam longint FX_FIFTH = (2 * FX_ONE + 5) / 10;
    localparam longint FX_EDGE  = (5 * FX_ONE) / 2;

    localparam cfg_index_t CFG_UNMAPPED = 2'd3;
    localparam mode_t      MODE_UNUSED  = 4'd15;

    localparam int RANDOM_PHASES = 30;
    localparam int PHASE_ITEMS   = 47;
    localparam int QUIET_PHASES  = 4;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [15:0] mode_word;
        fx_t         slope;
        fx_t         thresh;
        fx_t         smp;
        logic        typed;
        fx_t         want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 26;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{{12'h000, MODE_RELU}, RESET_SLOPE, RESET_THRESH, 16'sd32767, 1'b1, 16'sd32767},
        '{{12'h000, MODE_RELU}, RESET_SLOPE, RESET_THRESH, 16'sh8000, 1'b1, 16'sd0},
        '{{12'h000, MODE_RELU_SLOPE}, RESET_SLOPE, RESET_THRESH, 16'sd1, 1'b1, 16'sd4096},
        '{{12'h000, MODE_RELU_SLOPE}, RESET_SLOPE, RESET_THRESH, 16'sd0, 1'b1, 16'sd0},
        '{{12'h000, MODE_LEAKY}, RESET_SLOPE, RESET_THRESH, 16'sh8000, 1'b1, -16'sd328},
        '{{12'h000, MODE_LEAKY}, RESET_SLOPE, RESET_THRESH, -16'sd1, 1'b1, -16'sd1},
        '{{12'h000, MODE_LEAKY}, RESET_SLOPE, RESET_THRESH, 16'sd32767, 1'b1, 16'sd32767},
        '{{12'h000, MODE_LEAKY}, 16'sh8000, RESET_THRESH, 16'sh8000, 1'b1, 16'sd32767},
        '{{12'h000, MODE_LEAKY}, 16'sd32767, RESET_THRESH, 16'sh8000, 1'b1, 16'sh8000},
        '{{12'h000, MODE_LEAKY_SLOPE}, 16'sh8000, RESET_THRESH, 16'sd0, 1'b1, 16'sh8000},
        '{{12'h000, MODE_LEAKY_SLOPE}, 16'sh8000, RESET_THRESH, 16'sd5, 1'b1, 16'sd4096},
        '{{12'h000, MODE_HSIG}, RESET_SLOPE, RESET_THRESH, -16'sd10240, 1'b1, 16'sd0},
        '{{12'h000, MODE_HSIG}, RESET_SLOPE, RESET_THRESH, 16'sd10240, 1'b1, 16'sd4096},
        '{{12'h000, MODE_HSIG}, RESET_SLOPE, RESET_THRESH, -16'sd10239, 1'b0, 16'sd0},
        '{{12'h000, MODE_HSIG}, RESET_SLOPE, RESET_THRESH, 16'sd0, 1'b1, 16'sd2048},
        '{{12'h000, MODE_HSIG_SLOPE}, RESET_SLOPE, RESET_THRESH, 16'sd10239, 1'b1, 16'sd819},
        '{{12'h000, MODE_HSIG_SLOPE}, RESET_SLOPE, RESET_THRESH, -16'sd10240, 1'b1, 16'sd0},
        '{{12'h000, MODE_HTANH}, RESET_SLOPE, RESET_THRESH, 16'sh8000, 1'b1, -16'sd4096},
        '{{12'h000, MODE_HTANH}, RESET_SLOPE, RESET_THRESH, 16'sd4095, 1'b1, 16'sd4095},
        '{{12'h000, MODE_HTANH_SLOPE}, RESET_SLOPE, RESET_THRESH, -16'sd4096, 1'b1, 16'sd0},
        '{{12'h000, MODE_HTANH_SLOPE}, RESET_SLOPE, RESET_THRESH, -16'sd4095, 1'b1, 16'sd4096},
        '{{12'h000, MODE_THRESH}, RESET_SLOPE, RESET_THRESH, 16'sd4096, 1'b1, 16'sd0},
        '{{12'h000, MODE_THRESH}, RESET_SLOPE, 16'sh8000, -16'sd32767, 1'b1, -16'sd32767},
        '{{12'h000, MODE_THRESH_SLOPE}, RESET_SLOPE, 16'sd32767, 16'sd32767, 1'b1, 16'sd0},
        '{{12'hfff, MODE_LEAKY}, 16'sd32767, 16'sh8000, -16'sd12345, 1'b0, 16'sd0},
        '{{12'h000, MODE_UNUSED}, 16'sd32767, 16'sh8000, 16'sd12345, 1'b1, 16'sd0}
    };

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    fx_t        sample;
    logic       done;
    fx_t        activated;
    logic       cfg_valid;
    logic       cfg_ready;
    cfg_index_t cfg_index;
    fx_t        cfg_data;

    mode_t       act_mode   = RESET_MODE;
    fx_t         act_slope  = RESET_SLOPE;
    fx_t         act_thresh = RESET_THRESH;
    logic [15:0] act_mode_word = 16'h0000;

    fx_t pending_activated [$];
    int  mismatch_count = 0;

    piecewise_activation_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .sample    (sample),
        .done      (done),
        .activated (activated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic fx_t predict_activation(fx_t x);
        longint xv;
        longint sl;
        longint th;
        longint yv;
        xv = x;
        sl = act_slope;
        th = act_thresh;
        case (act_mode)
            MODE_RELU:         yv = (xv > 0) ? xv : 0;
            MODE_RELU_SLOPE:   yv = (xv > 0) ? FX_ONE : 0;
            MODE_LEAKY:        yv = (xv > 0) ? xv : ((xv * sl) >>> FRAC_BITS_DEFAULT);
            MODE_LEAKY_SLOPE:  yv = (xv > 0) ? FX_ONE : sl;
            MODE_HSIG:
            begin
                if (xv <= -FX_EDGE)
                    yv = 0;
                else if (xv >= FX_EDGE)
                    yv = FX_ONE;
                else
                    yv = ((FX_FIFTH * xv) >>> FRAC_BITS_DEFAULT) + FX_HALF;
            end
            MODE_HSIG_SLOPE:   yv = (xv <= -FX_EDGE || xv >= FX_EDGE) ? 0 : FX_FIFTH;
            MODE_HTANH:
            begin
                if (xv <= -FX_ONE)
                    yv = -FX_ONE;
                else if (xv >= FX_ONE)
                    yv = FX_ONE;
                else
                    yv = xv;
            end
            MODE_HTANH_SLOPE:  yv = (xv <= -FX_ONE || xv >= FX_ONE) ? 0 : FX_ONE;
            MODE_THRESH:       yv = (xv > th) ? xv : 0;
            MODE_THRESH_SLOPE: yv = (xv > th) ? FX_ONE : 0;
            default:           yv = 0;
        endcase
        if (yv > 32767)
            yv = 32767;
        else if (yv < -32768)
            yv = -32768;
        return fx_t'(yv);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] activated mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // compare each strobed result against the oldest pending request
    always @(posedge clk)
    begin
        fx_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_activated.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no request pending", activated));
            end
            else
            begin
                want = pending_activated.pop_front();
                if (activated !== want)
                begin
                    report_mismatch($sformatf("got %0d, want %0d", activated, want));
                end
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, fx_t data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            CFG_MODE:
            begin
                act_mode      = data[MODE_W-1:0];
                act_mode_word = data;
            end
            CFG_SLOPE:  act_slope  = data;
            CFG_THRESH: act_thresh = data;
            default:    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_activated.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(logic [15:0] mode_word, fx_t slope, fx_t thresh);
        wait_for_results();
        write_reg(CFG_UNMAPPED, fx_t'($urandom_range(0, 65535)));
        write_reg(CFG_MODE, fx_t'(mode_word));
        write_reg(CFG_SLOPE, slope);
        write_reg(CFG_THRESH, thresh);
    endtask

    task automatic idle_burst(bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_sample(fx_t x, bit typed, fx_t want);
        @(negedge clk);
        start  <= 1'b1;
        sample <= x;
        do @(posedge clk); while (busy !== 1'b0);
        pending_activated.push_back(typed ? want : predict_activation(x));
    endtask

    function automatic fx_t pick_setting();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return fx_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic fx_t rand_sample();
        int base;
        case ($urandom_range(0, 6))
            0, 1:
                return fx_t'($urandom_range(0, 65535));
            2:
                return fx_t'(int'($urandom_range(0, 40)) - 20);
            3:
            begin
                case ($urandom_range(0, 4))
                    0:       base = int'(FX_EDGE);
                    1:       base = -int'(FX_EDGE);
                    2:       base = int'(FX_ONE);
                    3:       base = -int'(FX_ONE);
                    default: base = act_thresh;
                endcase
                return fx_t'(base + int'($urandom_range(0, 6)) - 3);
            end
            4:
                return $urandom_range(0, 1) ? 16'sh8000 : 16'sd32767;
            default:
                return fx_t'(int'($urandom_range(0, 24575)) - 12288);
        endcase
    endfunction

    initial
    begin
        logic [11:0] upper;
        mode_t       m;
        bit          quiet;
        directed_row_t row;

        rst_n     = 1'b0;
        start     = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data  = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.mode_word != act_mode_word || row.slope != act_slope
                || row.thresh != act_thresh)
            begin
                apply_settings(row.mode_word, row.slope, row.thresh);
            end
            idle_burst(1'b0);
            send_sample(row.smp, row.typed, row.want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            m     = (p < 20) ? mode_t'(p % 10) : mode_t'($urandom_range(0, 15));
            upper = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095)) : 12'h000;
            apply_settings({upper, m}, pick_setting(), pick_setting());
            quiet = (p >= RANDOM_PHASES - QUIET_PHASES) || ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                idle_burst(quiet);
                send_sample(rand_sample(), 1'b0, 16'sd0);
            end
        end

        wait_for_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
